FILE: rtl/bgr_pkg.sv
// bgr_pkg: shared types, constants and helpers of the glyph row renderer
// no dependencies; imported by the front, back and top-level modules

package bgr_pkg;

  // defaults for the top-level parameters
  localparam int LINE_PITCH_DEF = 320;
  localparam int GLYPH_ROWS_DEF = 9;
  localparam int CHAR_COUNT_DEF = 256;

  // fixed field widths, sized for the largest legal parameter values
  localparam int WIDX_MAX_W  = 8;   // CHAR_COUNT up to 256
  localparam int GADDR_MAX_W = 13;  // CHAR_COUNT * GLYPH_ROWS up to 8192
  localparam int ROW_ADDR_W  = 18;
  localparam int CURSOR_W    = 16;

  typedef enum logic [1:0] {
    OP_LOAD_WIDTH,
    OP_LOAD_GLYPH,
    OP_DRAW
  } bgr_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_ROW
  } bgr_state_t;

  // one classified item between front and back
  typedef struct packed {
    bgr_op_t                 op;
    logic [WIDX_MAX_W-1:0]   widx;
    logic [GADDR_MAX_W-1:0]  gaddr;
    logic [7:0]              data;
    logic                    known;
    logic                    first;
    logic [CURSOR_W-1:0]     start_x;
    logic [ROW_ADDR_W-1:0]   line_base;
    logic [7:0]              ink;
  } bgr_entry_t;

  // leftmost min(w,8) bits set
  function automatic logic [7:0] left_bits(input logic [7:0] w);
    logic [7:0] m;
    if (w >= 8'd8) begin
      m = 8'hFF;
    end else begin
      m = ~(8'hFF >> w[2:0]);
    end
    return m;
  endfunction

endpackage

FILE: rtl/bgr_in_if.sv
// bgr_in_if: input channel of the glyph row renderer, load and draw items
// no dependencies

interface bgr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [11:0] load_address;
  logic [7:0]  load_data;
  logic [7:0]  char_code;
  logic        first_of_string;
  logic [15:0] start_x;
  logic [7:0]  line_y;
  logic [7:0]  ink_color;

  modport source (
    output valid, action, load_address, load_data, char_code,
           first_of_string, start_x, line_y, ink_color,
    input  ready
  );
  modport sink (
    input  valid, action, load_address, load_data, char_code,
           first_of_string, start_x, line_y, ink_color,
    output ready
  );
endinterface

FILE: rtl/bgr_out_if.sv
// bgr_out_if: output channel of the glyph row renderer, masked row writes
// no dependencies

interface bgr_out_if;
  logic        valid;
  logic        ready;
  logic [17:0] row_address;
  logic [7:0]  pixel_mask;
  logic [7:0]  pixel_color;
  logic        last_row;

  modport source (
    output valid, row_address, pixel_mask, pixel_color, last_row,
    input  ready
  );
  modport sink (
    input  valid, row_address, pixel_mask, pixel_color, last_row,
    output ready
  );
endinterface

FILE: rtl/bgr_ram.sv
// bgr_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module bgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/bgr_front.sv
// bgr_front: accepts input items, classifies loads and draws, and queues
// them for the back end; uses bgr_pkg and bgr_in_if

module bgr_front
  import bgr_pkg::*;
#(
  parameter int LINE_PITCH = LINE_PITCH_DEF,
  parameter int GLYPH_ROWS = GLYPH_ROWS_DEF,
  parameter int CHAR_COUNT = CHAR_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bgr_in_if.sink      items,
  output logic        q_valid,
  input  logic        q_ready,
  output bgr_entry_t  q_entry
);

  localparam int GLYPH_BYTES = CHAR_COUNT * GLYPH_ROWS;

  bgr_entry_t  entry;
  logic        drop;
  logic [13:0] goff;
  logic        is_width;
  logic        is_glyph;

  bgr_entry_t  q_mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  always_comb begin
    goff     = 14'(items.load_address) - 14'(CHAR_COUNT);
    is_width = 13'(items.load_address) < 13'(CHAR_COUNT);
    is_glyph = !is_width && (goff < 14'(GLYPH_BYTES));

    entry           = '0;
    entry.data      = items.load_data;
    entry.first     = items.first_of_string;
    entry.start_x   = items.start_x;
    entry.ink       = items.ink_color;
    entry.line_base = ROW_ADDR_W'(28'(items.line_y) * 28'(LINE_PITCH));
    drop            = 1'b0;

    if (!items.action) begin
      entry.op    = is_width ? OP_LOAD_WIDTH : OP_LOAD_GLYPH;
      entry.widx  = items.load_address[WIDX_MAX_W-1:0];
      entry.gaddr = goff[GADDR_MAX_W-1:0];
      drop        = !is_width && !is_glyph;
    end else begin
      entry.op    = OP_DRAW;
      entry.known = 9'(items.char_code) < 9'(CHAR_COUNT);
      // unknown codes read entry zero and are masked off in the back end
      if (entry.known) begin
        entry.widx  = items.char_code;
        entry.gaddr = GADDR_MAX_W'(16'(items.char_code) * 16'(GLYPH_ROWS));
      end
    end
  end

  assign items.ready = (count != 2'd2);
  assign push        = items.valid && items.ready && !drop;
  assign pop         = q_valid && q_ready;
  assign q_valid     = (count != 2'd0);
  assign q_entry     = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: rtl/bgr_back.sv
// bgr_back: executes queued items: font memory writes, glyph row reads,
// cursor upkeep and the output register; uses bgr_pkg, bgr_ram, bgr_out_if

module bgr_back
  import bgr_pkg::*;
#(
  parameter int LINE_PITCH = LINE_PITCH_DEF,
  parameter int GLYPH_ROWS = GLYPH_ROWS_DEF,
  parameter int CHAR_COUNT = CHAR_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  bgr_entry_t  q_entry,
  bgr_out_if.source   rows
);

  localparam int GLYPH_BYTES = CHAR_COUNT * GLYPH_ROWS;
  localparam int WIDX_W      = $clog2(CHAR_COUNT);
  localparam int GADDR_W     = $clog2(GLYPH_BYTES);
  localparam int ROW_W       = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

  bgr_state_t            state, state_next;
  logic [ROW_W-1:0]      row_cnt, row_cnt_next;
  logic [GADDR_W-1:0]    gaddr, gaddr_next;
  logic [ROW_ADDR_W-1:0] addr, addr_next;
  logic [CURSOR_W-1:0]   x_pos, x_pos_next;
  logic [CURSOR_W-1:0]   cursor, cursor_next;
  logic                  known, known_next;
  logic [7:0]            ink, ink_next;

  logic                  ovalid, ovalid_next;
  logic                  load_out;
  logic [ROW_ADDR_W-1:0] o_addr;
  logic [7:0]            o_mask;
  logic [7:0]            o_color;
  logic                  o_last;

  logic                  w_we, w_re;
  logic                  g_we, g_re;
  logic [GADDR_W-1:0]    g_raddr;
  logic [7:0]            w_rdata, g_rdata;
  logic [7:0]            width_eff;
  logic                  slot_free;
  logic                  is_last;
  logic [CURSOR_W-1:0]   x_sel;

  bgr_ram #(.WIDTH(8), .DEPTH(CHAR_COUNT)) u_width_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (q_entry.widx[WIDX_W-1:0]),
    .wdata (q_entry.data),
    .re    (w_re),
    .raddr (q_entry.widx[WIDX_W-1:0]),
    .rdata (w_rdata)
  );

  bgr_ram #(.WIDTH(8), .DEPTH(GLYPH_BYTES)) u_glyph_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (q_entry.gaddr[GADDR_W-1:0]),
    .wdata (q_entry.data),
    .re    (g_re),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  assign slot_free = !ovalid || rows.ready;
  assign is_last   = (row_cnt == ROW_W'(GLYPH_ROWS - 1));
  assign width_eff = known ? w_rdata : 8'd0;
  assign x_sel     = q_entry.first ? q_entry.start_x : cursor;

  always_comb begin
    state_next   = state;
    row_cnt_next = row_cnt;
    gaddr_next   = gaddr;
    addr_next    = addr;
    x_pos_next   = x_pos;
    cursor_next  = cursor;
    known_next   = known;
    ink_next     = ink;
    q_ready      = 1'b0;
    w_we         = 1'b0;
    w_re         = 1'b0;
    g_we         = 1'b0;
    g_re         = 1'b0;
    g_raddr      = gaddr + GADDR_W'(1);
    load_out     = 1'b0;

    unique case (state)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          unique case (q_entry.op)
            OP_LOAD_WIDTH: w_we = 1'b1;
            OP_LOAD_GLYPH: g_we = 1'b1;
            OP_DRAW: begin
              w_re         = 1'b1;
              g_re         = 1'b1;
              g_raddr      = q_entry.gaddr[GADDR_W-1:0];
              gaddr_next   = q_entry.gaddr[GADDR_W-1:0];
              x_pos_next   = x_sel;
              addr_next    = q_entry.line_base + ROW_ADDR_W'(x_sel);
              known_next   = q_entry.known;
              ink_next     = q_entry.ink;
              row_cnt_next = '0;
              state_next   = ST_ROW;
            end
            default: ;
          endcase
        end
      end
      ST_ROW: begin
        if (slot_free) begin
          load_out  = 1'b1;
          addr_next = addr + ROW_ADDR_W'(LINE_PITCH);
          if (is_last) begin
            row_cnt_next = '0;
            cursor_next  = x_pos + CURSOR_W'(width_eff);
            state_next   = ST_IDLE;
          end else begin
            // fetch the next glyph row while this one goes out
            g_re         = 1'b1;
            gaddr_next   = gaddr + GADDR_W'(1);
            row_cnt_next = row_cnt + ROW_W'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (load_out) begin
      ovalid_next = 1'b1;
    end else if (rows.ready) begin
      ovalid_next = 1'b0;
    end else begin
      ovalid_next = ovalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      row_cnt <= '0;
      cursor  <= '0;
      ovalid  <= 1'b0;
    end else begin
      state   <= state_next;
      row_cnt <= row_cnt_next;
      cursor  <= cursor_next;
      ovalid  <= ovalid_next;
    end
  end

  always_ff @(posedge clk) begin
    gaddr <= gaddr_next;
    addr  <= addr_next;
    x_pos <= x_pos_next;
    known <= known_next;
    ink   <= ink_next;
    if (load_out) begin
      o_addr  <= addr;
      o_mask  <= known ? (g_rdata & left_bits(width_eff)) : 8'd0;
      o_color <= ink;
      o_last  <= is_last;
    end
  end

  assign rows.valid       = ovalid;
  assign rows.row_address = o_addr;
  assign rows.pixel_mask  = o_mask;
  assign rows.pixel_color = o_color;
  assign rows.last_row    = o_last;

  // a stalled row waits in place
  a_row_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROW && !slot_free) |=> (state == ST_ROW && $stable(row_cnt)))
    else $error("row counter moved while output stalled");

  // the final row ends the draw and is presented flagged as last
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROW && slot_free && is_last)
      |=> (state == ST_IDLE && ovalid && rows.last_row))
    else $error("last row did not end the draw");

  // the queue is only drained between draws
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |-> (state == ST_IDLE && row_cnt == '0))
    else $error("queue popped during a draw");

  // cursor only changes on the final row of a draw
  a_cursor: assert property (@(posedge clk) disable iff (rst)
    !(state == ST_ROW && slot_free && is_last) |=> $stable(cursor))
    else $error("cursor moved outside a draw end");

endmodule

FILE: rtl/bitmap_glyph_row_renderer.sv
// bitmap_glyph_row_renderer: top level of the variable-width font renderer
// uses bgr_pkg, bgr_in_if, bgr_out_if, bgr_front, bgr_back
//
// Usage:
//   items (valid/ready): action 0 writes one byte of the font image at
//   load_address (CHAR_COUNT widths first, then GLYPH_ROWS row bytes per
//   glyph); loads past the image are dropped. action 1 draws char_code at
//   start_x (first_of_string) or at the kept cursor, on text line line_y.
//   rows (valid/ready): GLYPH_ROWS masked row writes per draw, last_row set
//   on the final one; the cursor then advances by the glyph width (16-bit).
//   Items pass through a two-entry queue into the back end, which takes one
//   per cycle when idle. A load is written as it is taken and leaves the back
//   end idle; a draw takes one width/glyph fetch, then one row per cycle from
//   the glyph memory read port while rows is ready. The first row of a draw
//   passes the queue, the width and glyph memory reads and the output register.
//   Reset clears the queue, the cursor and the output register; the font
//   memories are not cleared and must be loaded before drawing.
//   When rows stalls, the pending row holds in the output register, the
//   back end waits and the queue fills, after which items.ready drops.

module bitmap_glyph_row_renderer
  import bgr_pkg::*;
#(
  parameter int LINE_PITCH = LINE_PITCH_DEF,
  parameter int GLYPH_ROWS = GLYPH_ROWS_DEF,
  parameter int CHAR_COUNT = CHAR_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bgr_in_if.sink    items,
  bgr_out_if.source rows
);

  logic       q_valid;
  logic       q_ready;
  bgr_entry_t q_entry;

  bgr_front #(
    .LINE_PITCH (LINE_PITCH),
    .GLYPH_ROWS (GLYPH_ROWS),
    .CHAR_COUNT (CHAR_COUNT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry)
  );

  bgr_back #(
    .LINE_PITCH (LINE_PITCH),
    .GLYPH_ROWS (GLYPH_ROWS),
    .CHAR_COUNT (CHAR_COUNT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry),
    .rows    (rows)
  );

endmodule

FILE: tb/sv/bitmap_glyph_row_renderer_tb.sv
// bitmap_glyph_row_renderer_tb: self-checking bench for the glyph row renderer
// loads font bytes and draws strings, checks every row write against a local predictor
// depends on bgr_pkg, bgr_in_if, bgr_out_if and bitmap_glyph_row_renderer
`timescale 1ns / 100ps

localparam int PITCH      = bgr_pkg::LINE_PITCH_DEF;
localparam int ROWS       = bgr_pkg::GLYPH_ROWS_DEF;
localparam int CHARS      = bgr_pkg::CHAR_COUNT_DEF;
localparam int FONT_BYTES = CHARS + CHARS * ROWS;

localparam bit ACT_LOAD = 1'b0;
localparam bit ACT_DRAW = 1'b1;

typedef struct packed {
  bit        action;
  bit [11:0] load_address;
  bit [7:0]  load_data;
  bit [7:0]  char_code;
  bit        first_of_string;
  bit [15:0] start_x;
  bit [7:0]  line_y;
  bit [7:0]  ink_color;
} glyph_item_t;

typedef struct packed {
  bit [17:0] row_address;
  bit [7:0]  pixel_mask;
  bit [7:0]  pixel_color;
  bit        last_row;
} row_write_t;

typedef enum {RX_OPEN, RX_RANDOM, RX_SLOW, RX_PERIODIC} rx_mode_t;

class glyph_scoreboard;
  bit [7:0]   width_tab[CHARS];
  bit [7:0]   glyph_tab[CHARS * ROWS];
  bit [15:0]  cursor = '0;
  row_write_t due_q[$];
  int errors = 0;
  int loads = 0;
  int dropped_loads = 0;
  int draws = 0;
  int rows_checked = 0;

  // predict the row writes caused by one accepted transfer
  function void note_item(glyph_item_t it);
    bit [15:0]  x;
    bit [7:0]   w;
    bit [7:0]   lim;
    bit [7:0]   bits;
    bit         known;
    int         a;
    row_write_t r;
    if (it.action == ACT_LOAD) begin
      loads++;
      if (it.load_address < CHARS) begin
        width_tab[it.load_address] = it.load_data;
      end else if (it.load_address < FONT_BYTES) begin
        glyph_tab[it.load_address - CHARS] = it.load_data;
      end else begin
        dropped_loads++;
      end
      return;
    end
    draws++;
    x = it.first_of_string ? it.start_x : cursor;
    known = (it.char_code < CHARS);
    w = known ? width_tab[it.char_code] : 8'd0;
    lim = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < w) lim[7-b] = 1'b1;
    end
    for (int row = 0; row < ROWS; row++) begin
      bits = known ? glyph_tab[int'(it.char_code) * ROWS + row] : 8'd0;
      a = (int'(it.line_y) + row) * PITCH + int'(x);
      r.row_address = a[17:0];
      r.pixel_mask  = bits & lim;
      r.pixel_color = it.ink_color;
      r.last_row    = (row == ROWS - 1);
      due_q.push_back(r);
    end
    cursor = x + w;
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endfunction

  function void check_row(row_write_t got);
    row_write_t want;
    if (due_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected row write, expected none actual %h", $time, got);
      return;
    end
    want = due_q.pop_front();
    rows_checked++;
    compare_field("row_address", want.row_address, got.row_address);
    compare_field("pixel_mask", want.pixel_mask, got.pixel_mask);
    compare_field("pixel_color", want.pixel_color, got.pixel_color);
    compare_field("last_row", want.last_row, got.last_row);
  endfunction

  function int outstanding();
    return due_q.size();
  endfunction
endclass

module bitmap_glyph_row_renderer_tb;
  localparam int ITEM_GOAL    = 470;
  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   items_sent = 0;
  int   burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  bit is_loaded[CHARS];
  int loaded_q[$];

  glyph_scoreboard sb = new();

  bgr_in_if  in_ch();
  bgr_out_if out_ch();

  bitmap_glyph_row_renderer DUT (
    .clk   (clk),
    .rst   (rst),
    .items (in_ch),
    .rows  (out_ch)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("%0t: timed out with %0d row writes outstanding", $time, sb.outstanding());
      $display("FAIL");
      $finish;
    end
  end

  // receiver stalls follow a mode that is re-drawn at random: open, random, slow or periodic
  always @(posedge clk) begin
    if (cycles % 150 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_ch.ready <= 1'b1;
      RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_SLOW:   out_ch.ready <= ($urandom_range(0, 7) == 0);
      default:   out_ch.ready <= (cycles % 4 != 3);
    endcase
  end

  always @(posedge clk) begin
    glyph_item_t it;
    row_write_t  rw;
    if (!rst && in_ch.valid && in_ch.ready) begin
      it.action          = in_ch.action;
      it.load_address    = in_ch.load_address;
      it.load_data       = in_ch.load_data;
      it.char_code       = in_ch.char_code;
      it.first_of_string = in_ch.first_of_string;
      it.start_x         = in_ch.start_x;
      it.line_y          = in_ch.line_y;
      it.ink_color       = in_ch.ink_color;
      sb.note_item(it);
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      rw.row_address = out_ch.row_address;
      rw.pixel_mask  = out_ch.pixel_mask;
      rw.pixel_color = out_ch.pixel_color;
      rw.last_row    = out_ch.last_row;
      sb.check_row(rw);
    end
  end

  // sender works in bursts; a gap follows each burst
  task automatic send_item(input glyph_item_t it);
    in_ch.valid           <= 1'b1;
    in_ch.action          <= it.action;
    in_ch.load_address    <= it.load_address;
    in_ch.load_data       <= it.load_data;
    in_ch.char_code       <= it.char_code;
    in_ch.first_of_string <= it.first_of_string;
    in_ch.start_x         <= it.start_x;
    in_ch.line_y          <= it.line_y;
    in_ch.ink_color       <= it.ink_color;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  // unused fields carry random values so that the block must ignore them
  task automatic load_byte(input int addr, input bit [7:0] data);
    glyph_item_t it;
    it.action          = ACT_LOAD;
    it.load_address    = addr[11:0];
    it.load_data       = data;
    it.char_code       = $urandom;
    it.first_of_string = $urandom;
    it.start_x         = $urandom;
    it.line_y          = $urandom_range(0, 199);
    it.ink_color       = $urandom;
    send_item(it);
  endtask

  task automatic draw_char(input bit [7:0] code, input bit first, input bit [15:0] sx,
                           input bit [7:0] ly, input bit [7:0] ink);
    glyph_item_t it;
    it.action          = ACT_DRAW;
    it.load_address    = $urandom;
    it.load_data       = $urandom;
    it.char_code       = code;
    it.first_of_string = first;
    it.start_x         = sx;
    it.line_y          = ly;
    it.ink_color       = ink;
    send_item(it);
  endtask

  // width and all rows of one character, so later draws read only written bytes
  task automatic load_glyph(input int c, input bit [7:0] w);
    bit [7:0] bits;
    load_byte(c, w);
    for (int r = 0; r < ROWS; r++) begin
      case ($urandom_range(0, 7))
        0:       bits = 8'hFF;
        1:       bits = 8'h00;
        default: bits = $urandom;
      endcase
      load_byte(CHARS + c * ROWS + r, bits);
    end
    if (!is_loaded[c]) begin
      is_loaded[c] = 1'b1;
      loaded_q.push_back(c);
    end
  endtask

  initial begin
    bit [7:0]  edge_rows[ROWS] = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA,
                                   8'h55, 8'hFF, 8'h7E, 8'hC3};
    int        pick;
    int        n;
    int        c;
    bit [7:0]  w;
    bit [15:0] sx;
    bit [7:0]  ly;
    bit [7:0]  ink;
    bit        first;

    in_ch.valid           = 1'b0;
    in_ch.action          = ACT_LOAD;
    in_ch.load_address    = '0;
    in_ch.load_data       = '0;
    in_ch.char_code       = '0;
    in_ch.first_of_string = 1'b0;
    in_ch.start_x         = '0;
    in_ch.line_y          = '0;
    in_ch.ink_color       = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero-width glyph, widest glyph at the top of the image,
    // loads past the image, cursor wrap and zero advance
    load_glyph(0, 8'd0);
    load_byte(CHARS - 1, 8'd255);
    for (int r = 0; r < ROWS; r++) begin
      load_byte(FONT_BYTES - ROWS + r, edge_rows[r]);
    end
    is_loaded[CHARS-1] = 1'b1;
    loaded_q.push_back(CHARS - 1);
    load_byte(FONT_BYTES, 8'hFF);
    load_byte(4095, 8'hA5);
    draw_char(8'd255, 1'b1, 16'hFFFF, 8'd199, 8'hFF);
    draw_char(8'd255, 1'b0, 16'h0000, 8'd199, 8'h5A);
    draw_char(8'd0, 1'b0, 16'hFFFF, 8'd0, 8'h00);
    draw_char(8'd0, 1'b1, 16'h0000, 8'd0, 8'hA5);

    // random: glyph loads, loads past the image and overwrites, mostly strings drawn from loaded glyphs
    while (items_sent < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        case ($urandom_range(0, 9))
          0:       w = 8'd0;
          6, 7:    w = 8'd8;
          8:       w = $urandom_range(9, 15);
          9:       w = $urandom_range(16, 255);
          default: w = $urandom_range(1, 7);
        endcase
        load_glyph($urandom_range(0, CHARS - 1), w);
      end else if (pick < 27) begin
        load_byte($urandom_range(FONT_BYTES, 4095), $urandom);
      end else if (pick < 33) begin
        // overwrite one byte of a glyph that is already complete
        c = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
        if ($urandom_range(0, 2) == 0) begin
          load_byte(c, $urandom_range(0, 12));
        end else begin
          load_byte(CHARS + c * ROWS + $urandom_range(0, ROWS - 1), $urandom);
        end
      end else begin
        n = $urandom_range(1, 6);
        case ($urandom_range(0, 3))
          0:       sx = $urandom;
          1:       sx = $urandom_range(65500, 65535);
          default: sx = $urandom_range(0, 319);
        endcase
        case ($urandom_range(0, 5))
          0:       ly = 8'd0;
          1:       ly = 8'd199;
          default: ly = $urandom_range(0, 199);
        endcase
        ink = $urandom;
        first = ($urandom_range(0, 6) != 0);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 4) == 0) ink = $urandom;
          draw_char(loaded_q[$urandom_range(0, loaded_q.size() - 1)],
                    (i == 0) ? first : 1'b0, sx, ly, ink);
        end
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d font loads (%0d outside the image) and %0d characters drawn",
             sb.loads, sb.dropped_loads, sb.draws);
    $display("%0d row writes checked across %0d distinct glyphs, %0d errors",
             sb.rows_checked, loaded_q.size(), sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
